// ===== sv/adc_channel_scan_sequencer_macros.svh =====
// Assertion macros for the ADC channel scan sequencer.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_MACROS_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// plain property under clock and active-low reset
`define ACSS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ACSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ACSS_ASSERT(label, clk, rst_n, prop, msg)
`define ACSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ACSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/acss_pkg.sv =====
// Shared types and constants for the ADC channel scan sequencer.
// No dependencies; used by the channel interfaces and the top level.
package acss_pkg;

  localparam int NUM_CHANNELS = 8;

  localparam int TIME_W   = 32;
  localparam int RESULT_W = 10;
  localparam int CH_W     = 3;
  localparam int IDX_W    = 4;
  localparam int EN_W     = 8;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int MEM_DEPTH = 1 << CH_W;

  localparam logic [IDX_W-1:0] NUM_CH_IDX = IDX_W'(NUM_CHANNELS);

  localparam logic [EN_W-1:0]   ENABLE_RESET = '0;
  localparam logic [TIME_W-1:0] PERIOD_RESET = TIME_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_ENABLE = 1'b0,
    CFG_SCAN_PERIOD    = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_AWAIT = 2'd2
  } phase_e;

endpackage

// ===== sv/acss_in_if.sv =====
// Input channel of the ADC channel scan sequencer: one scheduler tick per item.
// Depends on acss_pkg for field widths.
interface acss_in_if;
  logic                          valid;
  logic                          ready;
  logic [acss_pkg::TIME_W-1:0]   now_ms;
  logic                          conversion_busy;
  logic [acss_pkg::RESULT_W-1:0] conversion_result;
  logic [acss_pkg::CH_W-1:0]     read_channel;

  modport source (output valid, now_ms, conversion_busy, conversion_result, read_channel,
                  input ready);
  modport sink   (input valid, now_ms, conversion_busy, conversion_result, read_channel,
                  output ready);
endinterface

// ===== sv/acss_out_if.sv =====
// Output channel of the ADC channel scan sequencer: one result item per tick.
// Depends on acss_pkg for field widths.
interface acss_out_if;
  logic                          valid;
  logic                          ready;
  logic                          start_conversion;
  logic [acss_pkg::CH_W-1:0]     start_channel;
  logic                          sample_stored;
  logic                          scan_active;
  logic [acss_pkg::RESULT_W-1:0] read_value;

  modport source (output valid, start_conversion, start_channel, sample_stored, scan_active,
                  read_value, input ready);
  modport sink   (input valid, start_conversion, start_channel, sample_stored, scan_active,
                  read_value, output ready);
endinterface

// ===== sv/adc_channel_scan_sequencer.sv =====
// ADC channel scan sequencer top level: phase control and the readings memory.
// Depends on acss_pkg, acss_in_if, acss_out_if and the assertion macro header.
//
// Usage:
//   in_i carries one scheduler tick per item (time, converter busy flag,
//   converter result, channel to read back). out_o returns one result item
//   per tick: conversion start and channel, store strobe, scan activity and
//   the stored reading of the requested channel before this tick's update.
//   The configuration port writes channel_enable (index 0) and
//   scan_period_ms (index 1), one register per write-enable cycle.
// Throughput and timing:
//   One item per clock sustained while out_o is not stalled. The result
//   of an item is in the output register in the cycle after it is accepted;
//   the readings memory read data register is that output register. Phase,
//   index and scan time update at the accept edge.
// Reset:
//   Phase idle, index and last scan time zero, enable zero, period 100.
//   All eight readings read as zero through per-entry valid flags, which
//   reset clears at once; no clearing pass is needed.
// Stall:
//   While out_o is stalled the result holds and in_i.ready stays low; a new
//   item is taken in the same cycle the held result is taken.
`include "adc_channel_scan_sequencer_macros.svh"

module adc_channel_scan_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [acss_pkg::CFG_W-1:0]      cfg_data_i,
  acss_in_if.sink                         in_i,
  acss_out_if.source                      out_o
);

  logic [acss_pkg::EN_W-1:0]     enable_q;
  logic [acss_pkg::TIME_W-1:0]   period_q;
  acss_pkg::phase_e              phase_q, phase_d;
  logic [acss_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [acss_pkg::TIME_W-1:0]   last_q, last_d;
  logic [acss_pkg::TIME_W-1:0]   elapsed;

  logic                          start_d, stored_d;
  logic [acss_pkg::CH_W-1:0]     chan_d;
  logic                          wr_en;
  logic [acss_pkg::CH_W-1:0]     wr_addr;

  logic [acss_pkg::RESULT_W-1:0] mem_q [acss_pkg::MEM_DEPTH];
  logic [acss_pkg::MEM_DEPTH-1:0] vld_q;
  logic [acss_pkg::RESULT_W-1:0] rd_data_q;
  logic                          rd_vld_q;

  logic                          out_valid_q;
  logic                          start_q, stored_q, active_q;
  logic [acss_pkg::CH_W-1:0]     chan_q;
  logic                          in_acc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign elapsed    = in_i.now_ms - last_q;
  assign wr_addr    = idx_q[acss_pkg::CH_W-1:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= acss_pkg::ENABLE_RESET;
      period_q <= acss_pkg::PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (acss_pkg::cfg_reg_e'(cfg_idx_i))
        acss_pkg::CFG_CHANNEL_ENABLE: enable_q <= cfg_data_i[acss_pkg::EN_W-1:0];
        acss_pkg::CFG_SCAN_PERIOD:    period_q <= cfg_data_i[acss_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // phase sequencing for one tick
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    last_d   = last_q;
    start_d  = 1'b0;
    chan_d   = '0;
    stored_d = 1'b0;
    wr_en    = 1'b0;
    unique case (phase_q)
      acss_pkg::PH_START: begin
        if (idx_q < acss_pkg::NUM_CH_IDX && enable_q[wr_addr]) begin
          start_d = 1'b1;
          chan_d  = wr_addr;
          phase_d = acss_pkg::PH_AWAIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      acss_pkg::PH_AWAIT: begin
        if (!in_i.conversion_busy) begin
          wr_en    = idx_q < acss_pkg::NUM_CH_IDX;
          stored_d = 1'b1;
          idx_d    = idx_q + 1'b1;
          phase_d  = acss_pkg::PH_START;
        end
      end
      default: begin
        // unused code behaves as idle
        phase_d = acss_pkg::PH_IDLE;
        if (elapsed > period_q) begin
          last_d  = in_i.now_ms;
          idx_d   = '0;
          phase_d = acss_pkg::PH_START;
        end
      end
    endcase
    if (idx_d >= acss_pkg::NUM_CH_IDX) begin
      phase_d = acss_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= acss_pkg::PH_IDLE;
      idx_q   <= '0;
      last_q  <= '0;
      vld_q   <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  // readings memory: read before write on the same edge gives the old value
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= mem_q[in_i.read_channel];
      rd_vld_q  <= vld_q[in_i.read_channel] &&
                   ({1'b0, in_i.read_channel} < acss_pkg::NUM_CH_IDX);
      if (wr_en) begin
        mem_q[wr_addr] <= in_i.conversion_result;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      start_q  <= start_d;
      chan_q   <= chan_d;
      stored_q <= stored_d;
      active_q <= phase_d != acss_pkg::PH_IDLE;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.start_conversion = start_q;
  assign out_o.start_channel    = chan_q;
  assign out_o.sample_stored    = stored_q;
  assign out_o.scan_active      = active_q;
  assign out_o.read_value       = rd_vld_q ? rd_data_q : '0;

  `ACSS_ASSERT_IMPL(a_active_idx, clk_i, rst_ni, phase_q != acss_pkg::PH_IDLE, idx_q < acss_pkg::NUM_CH_IDX, "scan active with index past last channel")
  `ACSS_ASSERT_IMPL(a_active_match, clk_i, rst_ni, out_valid_q, active_q == (phase_q != acss_pkg::PH_IDLE), "scan_active disagrees with phase")
  `ACSS_ASSERT_IMPL(a_start_await, clk_i, rst_ni, out_valid_q && start_q, phase_q == acss_pkg::PH_AWAIT, "start issued but not awaiting")
  `ACSS_ASSERT_IMPL(a_store_not_await, clk_i, rst_ni, out_valid_q && stored_q, phase_q != acss_pkg::PH_AWAIT, "store strobe while still awaiting")
  `ACSS_ASSERT_NEXT(a_write_valid, clk_i, rst_ni, in_acc && wr_en, vld_q[$past(wr_addr)], "written entry not marked valid")

endmodule
